// File: sv/obb_trigger_enter_exit_tracker_assert.svh
// assertion macros shared by the tracker rtl
`ifndef OBB_TRIGGER_ENTER_EXIT_TRACKER_ASSERT_SVH
`define OBB_TRIGGER_ENTER_EXIT_TRACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OBBT_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obbt check failed");

// next-cycle implication, checked out of reset
`define OBBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obbt check failed");

`endif

// File: sv/obbt_pkg.sv
// shared constants, types and tables of the trigger tracker
`default_nettype none
package obbt_pkg;

    localparam int MAX_TRACKED_BODIES = 16;
    localparam int ID_W      = 32;
    localparam int COORD_W   = 24;
    localparam int HALF_W    = 23;
    localparam int ANG_W     = 48;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int EV_W      = 3;
    localparam int Q_W       = 18;
    localparam int D_W       = COORD_W + 1;

    localparam logic signed [Q_W-1:0] Q16_ONE = 18'sd65536;

    typedef logic signed [Q_W-1:0] q16_t;
    typedef q16_t mat_t [9];

    typedef enum logic [1:0] {
        OP_PLAYER    = 2'd0,
        OP_ABSENT    = 2'd1,
        OP_BODY      = 2'd2,
        OP_FRAME_END = 2'd3
    } op_t;

    localparam logic [EV_W-1:0] EV_PLAYER_ENTER = 3'd0;
    localparam logic [EV_W-1:0] EV_PLAYER_EXIT  = 3'd1;
    localparam logic [EV_W-1:0] EV_PLAYER_STAY  = 3'd2;
    localparam logic [EV_W-1:0] EV_BODY_ENTER   = 3'd3;
    localparam logic [EV_W-1:0] EV_BODY_STAY    = 3'd4;
    localparam logic [EV_W-1:0] EV_BODY_EXIT    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EULER    = 3'd6;

    // broadcast command to every table cell
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            upd;
        logic            any_hit;
        logic            step;
    } cell_cmd_t;

    // signals passed from one cell to the next
    typedef struct packed {
        logic            hit;
        logic            free;
        logic            tok;
        logic            tok_seen;
        logic            pend;
        logic            due;
        logic [ID_W-1:0] handle;
    } cell_link_t;

    // cordic arc table, 2^32 per turn
    function automatic logic [29:0] arc_angle(input logic [3:0] idx);
        logic [29:0] v;
        case (idx)
            4'd0:    v = 30'd536870912;
            4'd1:    v = 30'd316933406;
            4'd2:    v = 30'd167458907;
            4'd3:    v = 30'd85004756;
            4'd4:    v = 30'd42667331;
            4'd5:    v = 30'd21354465;
            4'd6:    v = 30'd10679838;
            4'd7:    v = 30'd5340245;
            4'd8:    v = 30'd2670163;
            4'd9:    v = 30'd1335087;
            4'd10:   v = 30'd667544;
            4'd11:   v = 30'd333772;
            4'd12:   v = 30'd166886;
            4'd13:   v = 30'd83443;
            4'd14:   v = 30'd41722;
            default: v = 30'd20861;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: sv/obbt_cell.sv
// one slot of the body table, linked to its neighbors
`default_nettype none
module obbt_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  obbt_pkg::cell_cmd_t    cmd,
    input  obbt_pkg::cell_link_t   link_in,
    output obbt_pkg::cell_link_t   link_out
);
    import obbt_pkg::*;

    logic            valid_reg;
    logic            seen_reg;
    logic            tok_reg;
    logic [ID_W-1:0] handle_reg;
    logic            mine_hit;
    logic            first_hit;
    logic            first_free;
    logic            claim;
    logic            due;

    assign mine_hit   = valid_reg && (handle_reg == cmd.id);
    assign first_hit  = mine_hit && !link_in.hit;
    assign first_free = !valid_reg && !link_in.free;
    assign claim      = cmd.upd && !cmd.any_hit && first_free;
    assign due        = valid_reg && !seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else if (cmd.step)
        begin
            tok_reg <= link_in.tok;
            // token leaving: retire if unseen, clear seen
            if (tok_reg)
            begin
                seen_reg <= 1'b0;
                if (due)
                begin
                    valid_reg <= 1'b0;
                end
            end
        end
        else if (cmd.upd)
        begin
            if (first_hit)
            begin
                seen_reg <= 1'b1;
            end
            else if (claim)
            begin
                valid_reg <= 1'b1;
                seen_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            handle_reg <= cmd.id;
        end
    end

    assign link_out.hit      = link_in.hit || mine_hit;
    assign link_out.free     = link_in.free || !valid_reg;
    assign link_out.tok      = tok_reg;
    assign link_out.tok_seen = link_in.tok_seen || tok_reg;
    assign link_out.pend     = link_in.pend || (due && link_in.tok_seen);
    assign link_out.due      = link_in.due || (tok_reg && due);
    assign link_out.handle   = link_in.handle | (tok_reg ? handle_reg : '0);

endmodule
`default_nettype wire

// File: sv/obbt_rotor.sv
// rotation matrix from euler angles: shared cordic then shared multiplier
`default_nettype none
module obbt_rotor
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [obbt_pkg::ANG_W-1:0] angles,
    output logic                      busy,
    output obbt_pkg::mat_t            mat
);
    import obbt_pkg::*;

    typedef enum logic [3:0] {
        RT_IDLE   = 4'b0001,
        RT_CORDIC = 4'b0010,
        RT_MUL    = 4'b0100,
        RT_SUM    = 4'b1000
    } rt_state_t;

    localparam logic signed [32:0] X0 = 33'sd652032874;

    rt_state_t          state_reg;
    logic [ANG_W-1:0]   angles_reg;
    logic [1:0]         ang_sel_reg;
    logic [3:0]         iter_reg;
    logic [3:0]         step_reg;
    logic signed [32:0] x_reg, y_reg, z_reg;
    q16_t               trig_reg [6];
    q16_t               prod_reg [14];
    q16_t               mat_reg  [9];

    logic [15:0]        ang_cur;
    logic [29:0]        r_cur;
    logic signed [32:0] x_in, y_in, z_in, x_next, y_next, z_next, arc;
    logic signed [32:0] x_rnd, y_rnd;
    q16_t               c_v, s_v, co_v, si_v, op_a, op_b;
    logic signed [35:0] prod_full;
    logic signed [35:0] prod_rnd;

    function automatic q16_t clamp_q(input logic signed [18:0] v);
        q16_t res;
        if (v > 19'sd65536)
            res = Q16_ONE;
        else if (v < -19'sd65536)
            res = -Q16_ONE;
        else
            res = v[Q_W-1:0];
        return res;
    endfunction

    always_comb
    begin
        case (ang_sel_reg)
            2'd0:    ang_cur = angles_reg[47:32];
            2'd1:    ang_cur = angles_reg[31:16];
            default: ang_cur = angles_reg[15:0];
        endcase
    end

    assign r_cur = {ang_cur[13:0], 16'b0};
    assign x_in  = (iter_reg == 4'd0) ? X0 : x_reg;
    assign y_in  = (iter_reg == 4'd0) ? 33'sd0 : y_reg;
    assign z_in  = (iter_reg == 4'd0) ? $signed({3'b0, r_cur}) : z_reg;
    assign arc   = $signed({3'b0, arc_angle(iter_reg)});

    always_comb
    begin
        if (!z_in[32])
        begin
            x_next = x_in - (y_in >>> iter_reg);
            y_next = y_in + (x_in >>> iter_reg);
            z_next = z_in - arc;
        end
        else
        begin
            x_next = x_in + (y_in >>> iter_reg);
            y_next = y_in - (x_in >>> iter_reg);
            z_next = z_in + arc;
        end
        x_rnd = (x_next + 33'sd8192) >>> 14;
        y_rnd = (y_next + 33'sd8192) >>> 14;
        if (r_cur == '0)
        begin
            c_v = Q16_ONE;
            s_v = '0;
        end
        else
        begin
            c_v = clamp_q(x_rnd[18:0]);
            s_v = clamp_q(y_rnd[18:0]);
        end
        unique case (ang_cur[15:14])
            2'd0:    begin co_v = c_v;  si_v = s_v;  end
            2'd1:    begin co_v = -s_v; si_v = c_v;  end
            2'd2:    begin co_v = -c_v; si_v = -s_v; end
            default: begin co_v = s_v;  si_v = -c_v; end
        endcase
    end

    // operand schedule: trig order cy sy cx sx cz sz
    always_comb
    begin
        case (step_reg)
            4'd0:    begin op_a = trig_reg[1]; op_b = trig_reg[3]; end
            4'd1:    begin op_a = trig_reg[0]; op_b = trig_reg[3]; end
            4'd2:    begin op_a = trig_reg[0]; op_b = trig_reg[4]; end
            4'd3:    begin op_a = prod_reg[0]; op_b = trig_reg[5]; end
            4'd4:    begin op_a = prod_reg[0]; op_b = trig_reg[4]; end
            4'd5:    begin op_a = trig_reg[0]; op_b = trig_reg[5]; end
            4'd6:    begin op_a = trig_reg[1]; op_b = trig_reg[2]; end
            4'd7:    begin op_a = trig_reg[2]; op_b = trig_reg[5]; end
            4'd8:    begin op_a = trig_reg[2]; op_b = trig_reg[4]; end
            4'd9:    begin op_a = prod_reg[1]; op_b = trig_reg[5]; end
            4'd10:   begin op_a = trig_reg[1]; op_b = trig_reg[4]; end
            4'd11:   begin op_a = trig_reg[1]; op_b = trig_reg[5]; end
            4'd12:   begin op_a = prod_reg[1]; op_b = trig_reg[4]; end
            default: begin op_a = trig_reg[0]; op_b = trig_reg[2]; end
        endcase
        prod_full = op_a * op_b;
        prod_rnd  = (prod_full + 36'sd32768) >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= RT_IDLE;
            ang_sel_reg <= '0;
            iter_reg    <= '0;
            step_reg    <= '0;
            for (int k = 0; k < 9; k++)
            begin
                mat_reg[k] <= (k == 0 || k == 4 || k == 8) ? Q16_ONE : '0;
            end
        end
        else
        begin
            unique case (state_reg)
                RT_IDLE:
                begin
                    if (start)
                    begin
                        state_reg   <= RT_CORDIC;
                        ang_sel_reg <= '0;
                        iter_reg    <= '0;
                    end
                end
                RT_CORDIC:
                begin
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'd15)
                    begin
                        if (ang_sel_reg == 2'd2)
                        begin
                            state_reg <= RT_MUL;
                            step_reg  <= '0;
                        end
                        else
                        begin
                            ang_sel_reg <= ang_sel_reg + 2'd1;
                        end
                    end
                end
                RT_MUL:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd13)
                    begin
                        state_reg <= RT_SUM;
                    end
                end
                RT_SUM:
                begin
                    state_reg  <= RT_IDLE;
                    mat_reg[0] <= clamp_q({prod_reg[2][17], prod_reg[2]}
                                          + {prod_reg[3][17], prod_reg[3]});
                    mat_reg[1] <= clamp_q({prod_reg[4][17], prod_reg[4]}
                                          - {prod_reg[5][17], prod_reg[5]});
                    mat_reg[2] <= prod_reg[6];
                    mat_reg[3] <= prod_reg[7];
                    mat_reg[4] <= prod_reg[8];
                    mat_reg[5] <= -trig_reg[3];
                    mat_reg[6] <= clamp_q({prod_reg[9][17], prod_reg[9]}
                                          - {prod_reg[10][17], prod_reg[10]});
                    mat_reg[7] <= clamp_q({prod_reg[11][17], prod_reg[11]}
                                          + {prod_reg[12][17], prod_reg[12]});
                    mat_reg[8] <= prod_reg[13];
                end
                default:
                begin
                    state_reg <= RT_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == RT_IDLE && start)
        begin
            angles_reg <= angles;
        end
        if (state_reg == RT_CORDIC)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (iter_reg == 4'd15)
            begin
                trig_reg[{ang_sel_reg, 1'b0}] <= co_v;
                trig_reg[{ang_sel_reg, 1'b1}] <= si_v;
            end
        end
        if (state_reg == RT_MUL)
        begin
            prod_reg[step_reg] <= prod_rnd[Q_W-1:0];
        end
    end

    assign busy = (state_reg != RT_IDLE);
    assign mat  = mat_reg;

endmodule
`default_nettype wire

// File: sv/obbt_box.sv
// point in oriented box test, nine products on one multiplier
`default_nettype none
module obbt_box
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [obbt_pkg::COORD_W-1:0] px,
    input  logic signed [obbt_pkg::COORD_W-1:0] py,
    input  logic signed [obbt_pkg::COORD_W-1:0] pz,
    input  logic signed [obbt_pkg::COORD_W-1:0] cx,
    input  logic signed [obbt_pkg::COORD_W-1:0] cy,
    input  logic signed [obbt_pkg::COORD_W-1:0] cz,
    input  logic [obbt_pkg::HALF_W-1:0]        hx,
    input  logic [obbt_pkg::HALF_W-1:0]        hy,
    input  logic [obbt_pkg::HALF_W-1:0]        hz,
    input  obbt_pkg::mat_t                     mat,
    output logic                               done,
    output logic                               holds
);
    import obbt_pkg::*;

    logic signed [D_W-1:0] d_reg [3];
    logic                  run_reg;
    logic [1:0]            i_reg, j_reg;
    logic                  pv_reg, plast_reg;
    logic [1:0]            pj_reg;
    logic signed [42:0]    prod_reg;
    logic signed [44:0]    acc_reg;
    logic                  fail_reg, done_reg, holds_reg;

    logic [3:0]            m_idx;
    logic signed [44:0]    sum;
    logic [HALF_W-1:0]     h_sel;
    logic signed [44:0]    h_w;
    logic                  ok;

    assign m_idx = {1'b0, i_reg, 1'b0} + {2'b0, i_reg} + {2'b0, j_reg};
    assign sum   = acc_reg + {{2{prod_reg[42]}}, prod_reg};

    always_comb
    begin
        case (pj_reg)
            2'd0:    h_sel = hx;
            2'd1:    h_sel = hy;
            default: h_sel = hz;
        endcase
        h_w = $signed({6'b0, h_sel, 16'b0});
        ok  = !(sum > h_w) && !(sum < -h_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            pv_reg     <= 1'b0;
            fail_reg   <= 1'b0;
            done_reg   <= 1'b0;
            holds_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            pv_reg   <= run_reg;
            if (start)
            begin
                run_reg  <= 1'b1;
                i_reg    <= '0;
                j_reg    <= '0;
                fail_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                if (i_reg == 2'd2)
                begin
                    i_reg <= '0;
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd2)
                    begin
                        run_reg <= 1'b0;
                    end
                end
                else
                begin
                    i_reg <= i_reg + 2'd1;
                end
            end
            if (pv_reg && plast_reg)
            begin
                if (pj_reg == 2'd2)
                begin
                    done_reg  <= 1'b1;
                    holds_reg <= !fail_reg && ok;
                end
                else
                begin
                    fail_reg <= fail_reg || !ok;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg[0] <= {px[COORD_W-1], px} - {cx[COORD_W-1], cx};
            d_reg[1] <= {py[COORD_W-1], py} - {cy[COORD_W-1], cy};
            d_reg[2] <= {pz[COORD_W-1], pz} - {cz[COORD_W-1], cz};
            acc_reg  <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= plast_reg ? '0 : sum;
        end
        prod_reg  <= mat[m_idx] * d_reg[i_reg];
        plast_reg <= (i_reg == 2'd2);
        pj_reg    <= j_reg;
    end

    assign done  = done_reg;
    assign holds = holds_reg;

endmodule
`default_nettype wire

// File: sv/obb_trigger_enter_exit_tracker.sv
// top level of the oriented box trigger tracker
//
// input channel (in_valid/in_ready) takes one item per operation: player
// point, player absent, body point with handle, end of frame. output
// channel (out_valid/out_ready) gives enter, stay and exit events, with
// last_of_run set on the final event an item causes.
// a player point is held until its containment test is done: the nine
// products of the test share one multiplier, and its event is then
// loaded into the output register. a body point adds a table lookup
// state. a point that causes no event goes back to idle after the test.
// player absent is handled without leaving idle. end of frame sweeps a
// token down the chain of 16 table cells, one cell per cycle unless the
// receiver stalls on an exit event.
// writing euler_angles rebuilds the rotation matrix (three
// 16-step cordic runs, then 14 products on one multiplier); no item is
// taken meanwhile.
// the output register lets the next item be taken while an event waits;
// a stalled receiver holds the sweep and any new event until it drains.
// reset clears config to zero, the matrix to identity, the player flag
// and every table valid and seen bit.
`default_nettype none
module obb_trigger_enter_exit_tracker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [obbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [obbt_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           operation,
    input  logic [obbt_pkg::ID_W-1:0]            body_id,
    input  logic signed [obbt_pkg::COORD_W-1:0]  point_x,
    input  logic signed [obbt_pkg::COORD_W-1:0]  point_y,
    input  logic signed [obbt_pkg::COORD_W-1:0]  point_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [obbt_pkg::EV_W-1:0]            event_code,
    output logic [obbt_pkg::ID_W-1:0]            event_body,
    output logic                                 last_of_run,
    output logic                                 not_tracked
);
    import obbt_pkg::*;

`include "obb_trigger_enter_exit_tracker_assert.svh"

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CALC   = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_SWEEP  = 5'b10000
    } state_t;

    state_t                     state_reg;
    logic signed [COORD_W-1:0]  center_x_reg, center_y_reg, center_z_reg;
    logic [HALF_W-1:0]          half_x_reg, half_y_reg, half_z_reg;
    logic                       player_reg;
    logic [1:0]                 op_reg;
    logic [ID_W-1:0]            id_reg;

    // event waiting for the output register
    logic [EV_W-1:0]            pend_code_reg;
    logic [ID_W-1:0]            pend_body_reg;
    logic                       pend_nt_reg;

    logic                       out_valid_reg;
    logic [EV_W-1:0]            code_reg;
    logic [ID_W-1:0]            body_reg;
    logic                       last_reg;
    logic                       nt_reg;

    logic                       euler_wr;
    logic                       rot_busy;
    mat_t                       mat;
    logic                       accept;
    logic                       box_start;
    logic                       box_done;
    logic                       box_inside;
    logic                       out_free;
    logic                       out_load;
    logic [EV_W-1:0]            code_next;
    logic [ID_W-1:0]            body_next;
    logic                       last_next;
    logic                       nt_next;
    logic                       sweep_start;
    logic                       sweep_step;

    cell_cmd_t                  cmd;
    cell_link_t                 link [MAX_TRACKED_BODIES+1];
    logic                       any_hit, free_any, tok_any, pend_after, cur_due;
    logic [ID_W-1:0]            cur_handle;

    assign euler_wr  = cfg_we && (cfg_index == REG_EULER);
    assign in_ready  = (state_reg == ST_IDLE) && !rot_busy && !euler_wr;
    assign accept    = in_valid && in_ready;
    assign box_start = accept && (operation == OP_PLAYER || operation == OP_BODY);
    assign sweep_start = accept && (operation == OP_FRAME_END);
    assign out_free  = !out_valid_reg || out_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            half_x_reg   <= '0;
            half_y_reg   <= '0;
            half_z_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[COORD_W-1:0];
                REG_CENTER_Z: center_z_reg <= cfg_data[COORD_W-1:0];
                REG_HALF_X:   half_x_reg   <= cfg_data[HALF_W-1:0];
                REG_HALF_Y:   half_y_reg   <= cfg_data[HALF_W-1:0];
                REG_HALF_Z:   half_z_reg   <= cfg_data[HALF_W-1:0];
                default:      ;
            endcase
        end
    end

    obbt_rotor u_rotor
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (euler_wr),
        .angles (cfg_data[ANG_W-1:0]),
        .busy   (rot_busy),
        .mat    (mat)
    );

    obbt_box u_box
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (box_start),
        .px     (point_x),
        .py     (point_y),
        .pz     (point_z),
        .cx     (center_x_reg),
        .cy     (center_y_reg),
        .cz     (center_z_reg),
        .hx     (half_x_reg),
        .hy     (half_y_reg),
        .hz     (half_z_reg),
        .mat    (mat),
        .done   (box_done),
        .holds  (box_inside)
    );

    // body table: chain of cells, priority and sweep token ripple down it
    assign link[0] = '{hit: 1'b0, free: 1'b0, tok: sweep_start, tok_seen: 1'b0,
                       pend: 1'b0, due: 1'b0, handle: '0};

    for (genvar g = 0; g < MAX_TRACKED_BODIES; g++)
    begin : g_cell
        obbt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (link[g]),
            .link_out (link[g+1])
        );
    end

    assign any_hit    = link[MAX_TRACKED_BODIES].hit;
    assign free_any   = link[MAX_TRACKED_BODIES].free;
    assign tok_any    = link[MAX_TRACKED_BODIES].tok_seen;
    assign pend_after = link[MAX_TRACKED_BODIES].pend;
    assign cur_due    = link[MAX_TRACKED_BODIES].due;
    assign cur_handle = link[MAX_TRACKED_BODIES].handle;

    // sweep advances past a due cell only when its exit goes out
    assign sweep_step = (state_reg == ST_SWEEP) && tok_any && (!cur_due || out_free);

    assign cmd.id      = id_reg;
    assign cmd.upd     = (state_reg == ST_SEARCH);
    assign cmd.any_hit = any_hit;
    assign cmd.step    = sweep_start || sweep_step;

    // output register load
    always_comb
    begin
        out_load  = 1'b0;
        code_next = pend_code_reg;
        body_next = pend_body_reg;
        last_next = 1'b1;
        nt_next   = pend_nt_reg;
        if (state_reg == ST_EMIT && out_free)
        begin
            out_load = 1'b1;
        end
        else if (sweep_step && cur_due)
        begin
            out_load  = 1'b1;
            code_next = EV_BODY_EXIT;
            body_next = cur_handle;
            last_next = !pend_after;
            nt_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            player_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (operation)
                            OP_PLAYER, OP_BODY: state_reg <= ST_CALC;
                            OP_ABSENT:          player_reg <= 1'b0;
                            default:            state_reg <= ST_SWEEP;
                        endcase
                    end
                end
                ST_CALC:
                begin
                    if (box_done)
                    begin
                        if (op_reg == OP_PLAYER)
                        begin
                            player_reg <= box_inside;
                            state_reg  <= (box_inside || player_reg) ? ST_EMIT : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= box_inside ? ST_SEARCH : ST_IDLE;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SWEEP:
                begin
                    if (!tok_any)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= operation;
            id_reg <= body_id;
        end
        if (state_reg == ST_CALC && box_done)
        begin
            // enter on rise, exit on fall, stay while inside
            pend_body_reg <= '0;
            pend_nt_reg   <= 1'b0;
            if (box_inside != player_reg)
            begin
                pend_code_reg <= box_inside ? EV_PLAYER_ENTER : EV_PLAYER_EXIT;
            end
            else
            begin
                pend_code_reg <= EV_PLAYER_STAY;
            end
        end
        if (state_reg == ST_SEARCH)
        begin
            pend_code_reg <= any_hit ? EV_BODY_STAY : EV_BODY_ENTER;
            pend_body_reg <= id_reg;
            pend_nt_reg   <= !any_hit && !free_any;
        end
        if (out_load)
        begin
            code_reg <= code_next;
            body_reg <= body_next;
            last_reg <= last_next;
            nt_reg   <= nt_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_code  = code_reg;
    assign event_body  = body_reg;
    assign last_of_run = last_reg;
    assign not_tracked = nt_reg;

    `OBBT_ASSERT(a_busy_blocks_input, rot_busy, !in_ready)
    `OBBT_ASSERT_NEXT(a_frame_end_sweeps, sweep_start, state_reg == ST_SWEEP)
    `OBBT_ASSERT_NEXT(a_sweep_done_idles, (state_reg == ST_SWEEP) && !tok_any, state_reg == ST_IDLE)
    `OBBT_ASSERT(a_load_needs_room, out_load, out_free)

endmodule
`default_nettype wire
